// ----- sv/u8dec_pkg.sv -----
`default_nettype none

package u8dec_pkg;

  localparam int CpWidth = 31;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NUL     = 3'd1;
  localparam logic [2:0] ST_TRUNC   = 3'd2;
  localparam logic [2:0] ST_BADCONT = 3'd3;
  localparam logic [2:0] ST_STRAY   = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic [2:0]         status;
    logic               overlong;
    logic               end_of_string;
  } out_item_t;

  typedef struct packed {
    logic [2:0]         remaining;
    logic [2:0]         seq_len;
    logic [CpWidth-1:0] partial;
  } dec_state_t;

  // smallest value that really needs a sequence of the given length
  function automatic logic [CpWidth-1:0] min_for_len(input logic [2:0] len);
    logic [CpWidth-1:0] m;
    case (len)
      3'd2:    m = 31'h0000_0080;
      3'd3:    m = 31'h0000_0800;
      3'd4:    m = 31'h0001_0000;
      3'd5:    m = 31'h0020_0000;
      3'd6:    m = 31'h0400_0000;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- sv/u8dec_step.sv -----
`default_nettype none

module u8dec_step (
  input  u8dec_pkg::dec_state_t st,
  input  u8dec_pkg::in_item_t   item,
  output u8dec_pkg::dec_state_t st_next,
  output logic                  res_valid,
  output u8dec_pkg::out_item_t  res
);
  import u8dec_pkg::*;

  logic [7:0]         b;
  logic [CpWidth-1:0] acc;
  logic [2:0]         rem_dec;
  logic [2:0]         len;
  logic [CpWidth-1:0] lead;
  logic               is_lead;
  logic [CpWidth-1:0] fin_val;
  logic [2:0]         fin_len;
  logic               fin;

  assign b       = item.data_byte;
  assign acc     = {st.partial[CpWidth-7:0], b[5:0]};
  assign rem_dec = st.remaining - 3'd1;

  // lead byte classification
  always_comb begin
    is_lead = 1'b1;
    len     = 3'd0;
    lead    = '0;
    if (b[7:5] == 3'b110) begin
      len  = 3'd2;
      lead = {{(CpWidth-5){1'b0}}, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      len  = 3'd3;
      lead = {{(CpWidth-4){1'b0}}, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      len  = 3'd4;
      lead = {{(CpWidth-3){1'b0}}, b[2:0]};
    end else if (b[7:2] == 6'b111110) begin
      len  = 3'd5;
      lead = {{(CpWidth-2){1'b0}}, b[1:0]};
    end else if (b[7:1] == 7'b1111110) begin
      len  = 3'd6;
      lead = {{(CpWidth-1){1'b0}}, b[0]};
    end else begin
      is_lead = 1'b0;
    end
  end

  always_comb begin
    st_next           = st;
    res_valid         = 1'b0;
    res.code_point    = '0;
    res.status        = ST_OK;
    res.overlong      = 1'b0;
    res.end_of_string = item.last_byte;
    fin               = 1'b0;
    fin_val           = acc;
    fin_len           = st.seq_len;

    if (st.remaining == 3'd0) begin
      if (!b[7]) begin
        fin     = 1'b1;
        fin_val = {{(CpWidth-7){1'b0}}, b[6:0]};
        fin_len = 3'd1;
      end else if (!is_lead) begin
        res_valid  = 1'b1;
        res.status = ST_STRAY;
      end else if (item.last_byte) begin
        res_valid  = 1'b1;
        res.status = ST_TRUNC;
      end else begin
        st_next.seq_len   = len;
        st_next.remaining = len - 3'd1;
        st_next.partial   = lead;
      end
    end else if (item.last_byte && st.remaining > 3'd1) begin
      // truncation wins over a bad continuation
      res_valid  = 1'b1;
      res.status = ST_TRUNC;
      st_next    = '0;
    end else if (b[7:6] != 2'b10) begin
      res_valid  = 1'b1;
      res.status = ST_BADCONT;
      st_next    = '0;
    end else if (rem_dec == 3'd0) begin
      fin = 1'b1;
    end else begin
      st_next.remaining = rem_dec;
      st_next.partial   = acc;
    end

    if (fin) begin
      res_valid      = 1'b1;
      res.code_point = fin_val;
      res.status     = (fin_val == '0) ? ST_NUL : ST_OK;
      res.overlong   = (fin_len >= 3'd2) && (fin_val < min_for_len(fin_len));
      st_next        = '0;
    end
  end

endmodule

`default_nettype wire

// ----- sv/utf8_to_ucs32_decoder_top.sv -----
// a result is written into the result queue when the byte that completes it is accepted
// throughput: one byte per cycle while the result queue is not full, set by the combinational decode step
// a two-entry result queue lets bytes keep flowing while a result waits to be taken
// reset (rst, synchronous, active high) returns the decoder to idle and empties the queue
`default_nettype none

module utf8_to_ucs32_decoder_top (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  byte_valid,
  output logic                 byte_ready,
  input  u8dec_pkg::in_item_t  byte_item,
  output logic                 char_valid,
  input  wire                  char_ready,
  output u8dec_pkg::out_item_t char_item
);
  import u8dec_pkg::*;

  dec_state_t st;
  dec_state_t st_next;
  logic       res_valid;
  out_item_t  res;

  out_item_t  slot [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       take;
  logic       push;
  logic       pop;

  u8dec_step u_step (
    .st        (st),
    .item      (byte_item),
    .st_next   (st_next),
    .res_valid (res_valid),
    .res       (res)
  );

  assign byte_ready = (count != 2'd2);
  assign take       = byte_valid && byte_ready;
  assign push       = take && res_valid;
  assign pop        = char_valid && char_ready;
  assign char_valid = (count != 2'd0);
  assign char_item  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (take) begin
        st <= st_next;
      end
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= res;
    end
  end

endmodule

`default_nettype wire

// ----- sv/u8dec_chk.sv -----
`default_nettype none

module u8dec_chk (
  input wire                  clk,
  input wire                  rst,
  input wire                  char_valid,
  input wire                  char_ready,
  input u8dec_pkg::out_item_t char_item
);
  import u8dec_pkg::*;

  // nothing left over from before reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !char_valid)
    else $error("result offered right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_ready |=> char_valid && $stable(char_item))
    else $error("stalled result transaction changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    char_valid && char_item.status != ST_OK |-> char_item.code_point == '0)
    else $error("code point not cleared on non-ok status");

  a_ok_nonzero: assert property (@(posedge clk) disable iff (rst)
    char_valid && char_item.status == ST_OK |-> char_item.code_point != '0)
    else $error("zero code point reported as ok");

  // overlong only on a completed character; truncation always ends the string
  a_flags: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> (!char_item.overlong || char_item.status == ST_OK ||
                    char_item.status == ST_NUL) &&
                   (char_item.status != ST_TRUNC || char_item.end_of_string))
    else $error("inconsistent result flags");

endmodule

bind utf8_to_ucs32_decoder_top u8dec_chk u_chk (.*);

`default_nettype wire

// ----- tb/utf8_decoder_checker.sv -----
`timescale 1ns / 1ps

module utf8_decoder_checker (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  byte_valid,
  input  wire                  byte_ready,
  input  u8dec_pkg::in_item_t  byte_item,
  input  wire                  char_valid,
  input  wire                  char_ready,
  input  u8dec_pkg::out_item_t char_item,
  output int                   fail_count,
  output int                   outstanding
);
  import u8dec_pkg::*;

  // decoder state as seen from the byte stream
  logic [2:0]         conts_due;
  logic [2:0]         char_len;
  logic [CpWidth-1:0] accum;

  out_item_t expected_chars[$];

  function automatic out_item_t finished_char(input logic [CpWidth-1:0] v,
                                              input logic [2:0] n, input logic eos);
    out_item_t r;
    logic      longer;
    case (n)
      3'd2:    longer = v < 31'h0000_0080;
      3'd3:    longer = v < 31'h0000_0800;
      3'd4:    longer = v < 31'h0001_0000;
      3'd5:    longer = v < 31'h0020_0000;
      3'd6:    longer = v < 31'h0400_0000;
      default: longer = 1'b0;
    endcase
    r.code_point    = v;
    r.status        = (v == '0) ? ST_NUL : ST_OK;
    r.overlong      = longer;
    r.end_of_string = eos;
    return r;
  endfunction

  function automatic out_item_t failed_char(input logic [2:0] st, input logic eos);
    out_item_t r;
    r               = '0;
    r.status        = st;
    r.end_of_string = eos;
    return r;
  endfunction

  task automatic decode_byte(input in_item_t it, output bit made, output out_item_t res);
    logic [7:0]         b;
    logic               eos;
    logic [2:0]         n;
    logic [CpWidth-1:0] lead;
    b    = it.data_byte;
    eos  = it.last_byte;
    made = 1'b1;
    n    = 3'd0;
    lead = '0;
    res  = '0;
    if (conts_due == 3'd0) begin
      casez (b)
        8'b0???????: n = 3'd1;
        8'b110?????: begin n = 3'd2; lead = {{(CpWidth-5){1'b0}}, b[4:0]}; end
        8'b1110????: begin n = 3'd3; lead = {{(CpWidth-4){1'b0}}, b[3:0]}; end
        8'b11110???: begin n = 3'd4; lead = {{(CpWidth-3){1'b0}}, b[2:0]}; end
        8'b111110??: begin n = 3'd5; lead = {{(CpWidth-2){1'b0}}, b[1:0]}; end
        8'b1111110?: begin n = 3'd6; lead = {{(CpWidth-1){1'b0}}, b[0]}; end
        default:     n = 3'd0;
      endcase
      if (n == 3'd1) begin
        res = finished_char({{(CpWidth-7){1'b0}}, b[6:0]}, n, eos);
      end else if (n == 3'd0) begin
        res = failed_char(ST_STRAY, eos);
      end else if (eos) begin
        res = failed_char(ST_TRUNC, 1'b1);
      end else begin
        made      = 1'b0;
        conts_due = n - 3'd1;
        char_len  = n;
        accum     = lead;
      end
    end else if (eos && conts_due > 3'd1) begin
      // truncation wins over a malformed continuation
      res = failed_char(ST_TRUNC, 1'b1);
    end else if (b[7:6] != 2'b10) begin
      res = failed_char(ST_BADCONT, eos);
    end else begin
      accum     = {accum[CpWidth-7:0], b[5:0]};
      conts_due = conts_due - 3'd1;
      if (conts_due == 3'd0) res = finished_char(accum, char_len, eos);
      else made = 1'b0;
    end
    if (made) begin
      conts_due = '0;
      char_len  = '0;
      accum     = '0;
    end
  endtask

  task automatic report(input string what);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $time, what);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    bit        made;
    if (rst) begin
      expected_chars.delete();
      conts_due = '0;
      char_len  = '0;
      accum     = '0;
    end else begin
      // results are registered in the decoder's result queue, so check before predicting
      if (char_valid && char_ready) begin
        if (expected_chars.size() == 0) begin
          report($sformatf("unexpected transaction: cp %h st %0d ovl %0b eos %0b",
                           char_item.code_point, char_item.status,
                           char_item.overlong, char_item.end_of_string));
        end else begin
          want = expected_chars.pop_front();
          if (char_item.code_point !== want.code_point || char_item.status !== want.status ||
              char_item.overlong !== want.overlong ||
              char_item.end_of_string !== want.end_of_string) begin
            report($sformatf({"mismatch: expected cp %h st %0d ovl %0b eos %0b,",
                              " got cp %h st %0d ovl %0b eos %0b"},
                             want.code_point, want.status, want.overlong,
                             want.end_of_string, char_item.code_point, char_item.status,
                             char_item.overlong, char_item.end_of_string));
          end
        end
      end
      if (byte_valid && byte_ready) begin
        decode_byte(byte_item, made, got);
        if (made) expected_chars.push_back(got);
      end
    end
    outstanding = expected_chars.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import u8dec_pkg::*;

  localparam int TotalBytes  = 950;
  localparam int QuietFrom   = 800;
  localparam int StallLimit  = 3000;
  localparam int LongHold    = 80;
  localparam int DrainCycles = 20;

  logic      clk        = 1'b0;
  logic      rst        = 1'b1;
  logic      byte_valid = 1'b0;
  logic      char_ready = 1'b0;
  in_item_t  byte_item  = '0;
  logic      byte_ready;
  logic      char_valid;
  out_item_t char_item;

  int fail_count;
  int outstanding;
  int bytes_sent    = 0;
  int idle_cycles   = 0;
  bit quiet_tail    = 1'b0;
  bit long_hold_due = 1'b0;

  // data byte and last flag
  logic [8:0] directed_bytes [24] = '{
    {8'h00, 1'b0}, {8'h7f, 1'b0},
    {8'hc0, 1'b0}, {8'h80, 1'b0},
    {8'hdf, 1'b0}, {8'hbf, 1'b0},
    {8'hfd, 1'b0}, {8'hbf, 1'b0}, {8'hbf, 1'b0}, {8'hbf, 1'b0}, {8'hbf, 1'b0},
    {8'hbf, 1'b1},
    {8'h80, 1'b0}, {8'hfe, 1'b0}, {8'hff, 1'b1},
    {8'he0, 1'b0}, {8'h41, 1'b0},
    {8'hf0, 1'b1},
    {8'he2, 1'b0}, {8'h82, 1'b1},
    {8'he2, 1'b0}, {8'hc0, 1'b1},
    {8'hc2, 1'b0}, {8'hc0, 1'b1}
  };

  utf8_to_ucs32_decoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .byte_item (byte_item),
    .char_valid(char_valid),
    .char_ready(char_ready),
    .char_item (char_item)
  );

  utf8_decoder_checker char_check (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_item  (char_item),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (char_valid && char_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("[utf8_to_ucs32_decoder_top] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [7:0] lead_byte(input int len, input logic [7:0] r);
    case (len)
      2:       return {3'b110, r[4:0]};
      3:       return {4'b1110, r[3:0]};
      4:       return {5'b11110, r[2:0]};
      5:       return {6'b111110, r[1:0]};
      6:       return {7'b1111110, r[0]};
      default: return {1'b0, r[6:0]};
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = 0;
    if (!quiet_tail && ((bytes_sent >> 6) % 3 != 2) && $urandom_range(0, 4) == 0)
      gap = $urandom_range(1, 14);
    @(negedge clk);
    if (gap > 0) begin
      byte_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_item.data_byte = b;
    byte_item.last_byte = eos;
    byte_valid          = 1'b1;
    do @(posedge clk); while (!byte_ready);
    bytes_sent++;
  endtask

  // receiver side: random back-pressure, plus a long hold when asked for
  initial begin
    int n;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (long_hold_due) begin
        char_ready = 1'b0;
        repeat (LongHold) @(negedge clk);
        long_hold_due = 1'b0;
      end else if (!quiet_tail && ((bytes_sent >> 5) % 3 != 1) &&
                   $urandom_range(0, 4) == 0) begin
        char_ready = 1'b0;
        n = $urandom_range(1, 14);
        repeat (n - 1) @(negedge clk);
      end else begin
        char_ready = 1'b1;
      end
    end
  end

  initial begin
    logic [7:0] seq [$];
    logic [7:0] r;
    int         kind;
    int         len;
    int         count;
    int         holds;
    bit         tail_flag;
    holds = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_bytes[i]) send_byte(directed_bytes[i][8:1], directed_bytes[i][0]);

    while (bytes_sent < TotalBytes) begin
      quiet_tail = (bytes_sent >= QuietFrom);
      if ((holds == 0 && bytes_sent >= 300) || (holds == 1 && bytes_sent >= 600)) begin
        long_hold_due = 1'b1;
        holds++;
      end
      kind = $urandom_range(0, 99);
      if (kind >= 88) begin
        // line noise
        count = $urandom_range(1, 3);
        repeat (count) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
      end else begin
        len = (kind < 65) ? $urandom_range(1, 6) : $urandom_range(2, 6);
        seq.delete();
        r = 8'($urandom);
        seq.push_back(lead_byte(len, r));
        for (int i = 1; i < len; i++) begin
          r = 8'($urandom);
          seq.push_back({2'b10, r[5:0]});
        end
        tail_flag = ($urandom_range(0, 7) == 0);
        count     = len;
        if (kind >= 78) begin
          // broken continuation somewhere after the lead
          count = $urandom_range(1, len - 1);
          r     = 8'($urandom);
          if (r[7:6] == 2'b10) r[6] = 1'b1;
          seq[count] = r;
          count++;
        end else if (kind >= 65) begin
          // string ends in the middle of the sequence
          count     = $urandom_range(1, len - 1);
          tail_flag = 1'b1;
        end
        for (int i = 0; i < count; i++) send_byte(seq[i], (i == count - 1) && tail_flag);
      end
    end

    @(negedge clk);
    byte_valid = 1'b0;
    wait (outstanding == 0);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[utf8_to_ucs32_decoder_top] OK");
    end else begin
      $display("[utf8_to_ucs32_decoder_top] ERROR");
    end
    $finish;
  end

endmodule
